FILE: rtl/core/lln_pkg.sv
// Shared types and constants for the least-loaded node allocator.
`default_nettype none

package lln_pkg;

    localparam int MAX_NODES_DEF  = 16;
    localparam int LOAD_WIDTH_DEF = 16;

    localparam int REQ_COUNT_W   = 5;
    localparam int CFG_W         = 5;
    localparam int NODE_INDEX_W  = 4;
    localparam int LOAD_BEFORE_W = 16;

    localparam logic [CFG_W-1:0] NODES_IN_USE_RESET = 5'd16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [REQ_COUNT_W-1:0] count;
        logic                   error;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_xfer_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/lln_front.sv
// Front end: node count register, request intake and classification.
`default_nettype none

module lln_front #(
    parameter int MAX_NODES = lln_pkg::MAX_NODES_DEF,
    parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [lln_pkg::CFG_W-1:0]        cfg_wr_data,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire logic [lln_pkg::REQ_COUNT_W-1:0]  request_count,
    input  wire logic                             q_full,
    output lln_pkg::job_xfer_t                    q_push,
    output logic [CNT_W-1:0]                      eff_nodes
);

    localparam int CMP_W = (CNT_W > lln_pkg::CFG_W) ? CNT_W : lln_pkg::CFG_W;

    logic [lln_pkg::CFG_W-1:0] nodes_in_use_reg;
    logic [lln_pkg::CFG_W-1:0] nodes_in_use_next;
    logic [CMP_W-1:0]          cfg_cmp;
    logic [CMP_W-1:0]          max_cmp;
    logic [CMP_W-1:0]          eff_cmp;
    logic [CMP_W-1:0]          want_cmp;

    always_comb
    begin
        nodes_in_use_next = cfg_wr_en ? cfg_wr_data : nodes_in_use_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_in_use_reg <= lln_pkg::NODES_IN_USE_RESET;
        end
        else
        begin
            nodes_in_use_reg <= nodes_in_use_next;
        end
    end

    // Clamp the register to the number of counters that exist.
    always_comb
    begin
        cfg_cmp  = CMP_W'(nodes_in_use_reg);
        max_cmp  = CMP_W'(MAX_NODES);
        eff_cmp  = (cfg_cmp > max_cmp) ? max_cmp : cfg_cmp;
        want_cmp = CMP_W'(request_count);
    end

    assign eff_nodes = CNT_W'(eff_cmp);
    assign req_ready = !q_full;

    // Drop zero requests; flag requests larger than the node pool.
    always_comb
    begin
        q_push.valid     = req_valid && req_ready && (request_count != '0);
        q_push.job.count = request_count;
        q_push.job.error = (want_cmp > eff_cmp);
    end

endmodule

`default_nettype wire

FILE: rtl/core/lln_queue.sv
// Short job queue between the front end and the allocation engine.
`default_nettype none

module lln_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  lln_pkg::job_xfer_t push,
    output logic               full,
    output lln_pkg::job_xfer_t head,
    input  wire logic          pop
);

    lln_pkg::job_t                entry_reg [lln_pkg::QUEUE_DEPTH];
    logic [lln_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [lln_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [lln_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [lln_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [lln_pkg::QCNT_W-1:0]   count_reg;
    logic [lln_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full     = (count_reg == lln_pkg::QCNT_W'(lln_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push.valid && !full;
        do_pop      = pop && head.valid;
        wr_ptr_next = do_push ? wr_ptr_reg + lln_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + lln_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + lln_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - lln_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lln_back.sv
// Allocation engine: load memory, per-node minimum scan and result register.
`default_nettype none

module lln_back #(
    parameter int MAX_NODES  = lln_pkg::MAX_NODES_DEF,
    parameter int LOAD_WIDTH = lln_pkg::LOAD_WIDTH_DEF,
    parameter int CNT_W      = $clog2(MAX_NODES + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  lln_pkg::job_xfer_t                      head,
    output logic                                    pop,
    input  wire logic [CNT_W-1:0]                   eff_nodes,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output logic [lln_pkg::NODE_INDEX_W-1:0]        node_index,
    output logic [lln_pkg::LOAD_BEFORE_W-1:0]       load_before,
    output logic                                    last_of_run,
    output logic                                    request_error
);

    localparam int IDX_W = $clog2(MAX_NODES);

    lln_pkg::back_state_t state_reg;
    lln_pkg::back_state_t state_next;

    logic [lln_pkg::REQ_COUNT_W-1:0] rem_reg;
    logic [lln_pkg::REQ_COUNT_W-1:0] rem_next;
    logic [IDX_W-1:0]                scan_idx_reg;
    logic [IDX_W-1:0]                scan_idx_next;
    logic                            issue_done_reg;
    logic                            issue_done_next;
    logic                            pend_reg;
    logic                            pend_next;
    logic [IDX_W-1:0]                pend_idx_reg;
    logic                            found_reg;
    logic                            found_next;
    logic [IDX_W-1:0]                best_idx_reg;
    logic [IDX_W-1:0]                best_idx_next;
    logic [LOAD_WIDTH-1:0]           best_load_reg;
    logic [LOAD_WIDTH-1:0]           best_load_next;
    logic [MAX_NODES-1:0]            taken_reg;
    logic [MAX_NODES-1:0]            taken_next;

    logic [LOAD_WIDTH-1:0]           load_mem [MAX_NODES];
    logic [MAX_NODES-1:0]            ld_valid_reg;
    logic [MAX_NODES-1:0]            ld_valid_next;
    logic [LOAD_WIDTH-1:0]           rd_data_reg;
    logic                            rd_live_reg;
    logic                            rd_en;
    logic                            mem_we;
    logic [LOAD_WIDTH-1:0]           sat_load;
    logic [LOAD_WIDTH-1:0]           cand_load;
    logic                            last_issue;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_load;
    logic [lln_pkg::NODE_INDEX_W-1:0]  out_idx_reg;
    logic [lln_pkg::NODE_INDEX_W-1:0]  out_idx_next;
    logic [lln_pkg::LOAD_BEFORE_W-1:0] out_ld_reg;
    logic [lln_pkg::LOAD_BEFORE_W-1:0] out_ld_next;
    logic                            out_last_reg;
    logic                            out_last_next;
    logic                            out_err_reg;
    logic                            out_err_next;
    logic                            out_free;

    assign res_valid     = out_valid_reg;
    assign node_index    = out_idx_reg;
    assign load_before   = out_ld_reg;
    assign last_of_run   = out_last_reg;
    assign request_error = out_err_reg;

    assign out_free   = !out_valid_reg || res_ready;
    assign cand_load  = rd_live_reg ? rd_data_reg : '0;
    assign sat_load   = (best_load_reg == '1) ? best_load_reg
                                              : best_load_reg + LOAD_WIDTH'(1);
    assign last_issue = (CNT_W'(scan_idx_reg) == eff_nodes - CNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_load_next  = best_load_reg;
        taken_next      = taken_reg;
        ld_valid_next   = ld_valid_reg;
        rd_en           = 1'b0;
        mem_we          = 1'b0;
        pop             = 1'b0;
        out_load        = 1'b0;
        out_idx_next    = out_idx_reg;
        out_ld_next     = out_ld_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;

        case (state_reg)
            lln_pkg::BK_IDLE:
            begin
                if (head.valid && head.job.error)
                begin
                    if (out_free)
                    begin
                        pop           = 1'b1;
                        out_load      = 1'b1;
                        out_idx_next  = '0;
                        out_ld_next   = '0;
                        out_last_next = 1'b1;
                        out_err_next  = 1'b1;
                    end
                end
                else if (head.valid)
                begin
                    pop             = 1'b1;
                    rem_next        = head.job.count;
                    taken_next      = '0;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    state_next      = lln_pkg::BK_SCAN;
                end
            end

            lln_pkg::BK_SCAN:
            begin
                // Issue one counter read per cycle; compare its data in the cycle after.
                if (!issue_done_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    if (last_issue)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                if (pend_reg && !taken_reg[pend_idx_reg]
                    && (!found_reg || cand_load < best_load_reg))
                begin
                    found_next     = 1'b1;
                    best_idx_next  = pend_idx_reg;
                    best_load_next = cand_load;
                end
                if (issue_done_reg && !pend_reg)
                begin
                    state_next = lln_pkg::BK_EMIT;
                end
            end

            lln_pkg::BK_EMIT:
            begin
                // Hold the winner until the result register is free.
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_idx_next  = lln_pkg::NODE_INDEX_W'(best_idx_reg);
                    out_ld_next   = lln_pkg::LOAD_BEFORE_W'(best_load_reg);
                    out_last_next = (rem_reg == lln_pkg::REQ_COUNT_W'(1));
                    out_err_next  = 1'b0;
                    mem_we        = 1'b1;
                    ld_valid_next[best_idx_reg] = 1'b1;
                    taken_next[best_idx_reg]    = 1'b1;
                    rem_next      = rem_reg - lln_pkg::REQ_COUNT_W'(1);
                    if (rem_reg == lln_pkg::REQ_COUNT_W'(1))
                    begin
                        state_next = lln_pkg::BK_IDLE;
                    end
                    else
                    begin
                        scan_idx_next   = '0;
                        issue_done_next = 1'b0;
                        found_next      = 1'b0;
                        state_next      = lln_pkg::BK_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = lln_pkg::BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lln_pkg::BK_IDLE;
            rem_reg        <= '0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            taken_reg      <= '0;
            ld_valid_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rem_reg        <= rem_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            taken_reg      <= taken_next;
            ld_valid_reg   <= ld_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_load_reg <= best_load_next;
        out_idx_reg   <= out_idx_next;
        out_ld_reg    <= out_ld_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
        if (rd_en)
        begin
            pend_idx_reg <= scan_idx_reg;
        end
    end

    // Load memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            load_mem[best_idx_reg] <= sat_load;
        end
        if (rd_en)
        begin
            rd_data_reg <= load_mem[scan_idx_reg];
            rd_live_reg <= ld_valid_reg[scan_idx_reg];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/least_loaded_node_allocator_core.sv
// Top level of the least-loaded node allocator.
//
// Request channel (req_valid/req_ready, request_count) carries job requests;
// the result channel (res_valid/res_ready) returns one transfer per chosen
// node, lowest load first, ties to the lower index, with last_of_run on the
// final node. A request larger than the node pool returns one transfer with
// request_error set; a request for zero nodes returns nothing.
// cfg_wr_en/cfg_wr_data write nodes_in_use; write it only while idle.
//
// A request is taken from the queue while the engine is idle; then, for each
// chosen node, the engine reads the counters of the N nodes in use at one
// per cycle, settles the last compare and loads the result register.
// An error result passes from the queue to the result register.
// A two-entry queue sits between intake and engine, so requests are taken
// while the engine works; req_ready drops only when that queue is full.
// When res_ready is low the engine holds its winner and the result register
// holds its transfer. Reset clears all loads to zero and sets nodes_in_use
// to 16.
`default_nettype none

module least_loaded_node_allocator_core #(
    parameter int MAX_NODES  = lln_pkg::MAX_NODES_DEF,
    parameter int LOAD_WIDTH = lln_pkg::LOAD_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lln_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic [lln_pkg::REQ_COUNT_W-1:0]   request_count,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output logic [lln_pkg::NODE_INDEX_W-1:0]       node_index,
    output logic [lln_pkg::LOAD_BEFORE_W-1:0]      load_before,
    output logic                                   last_of_run,
    output logic                                   request_error
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (CNT_W > lln_pkg::NODE_INDEX_W) ? CNT_W : lln_pkg::NODE_INDEX_W;

    lln_pkg::job_xfer_t q_push;
    lln_pkg::job_xfer_t q_head;
    logic               q_full;
    logic               q_pop;
    logic [CNT_W-1:0]   eff_nodes;

    lln_front #(
        .MAX_NODES (MAX_NODES),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .request_count (request_count),
        .q_full        (q_full),
        .q_push        (q_push),
        .eff_nodes     (eff_nodes)
    );

    lln_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    lln_back #(
        .MAX_NODES  (MAX_NODES),
        .LOAD_WIDTH (LOAD_WIDTH),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .pop           (q_pop),
        .eff_nodes     (eff_nodes),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .node_index    (node_index),
        .load_before   (load_before),
        .last_of_run   (last_of_run),
        .request_error (request_error)
    );

`ifndef SYNTHESIS
    a_error_result_shape: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && request_error)
            |-> (last_of_run && node_index == '0 && load_before == '0)
    ) else $error("error result carries a node or a load");

    a_node_in_pool: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !request_error)
            |-> (CMP_W'(node_index) < CMP_W'(eff_nodes))
    ) else $error("chosen node lies outside the node pool");

    a_zero_request_dropped: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && request_count == '0) |-> !q_push.valid
    ) else $error("zero-node request entered the job queue");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_least_loaded_node_allocator_core.sv
// Self-checking testbench for the least-loaded node allocator core.
`default_nettype none

module tb_least_loaded_node_allocator_core;

    localparam int NODE_COUNT   = lln_pkg::MAX_NODES_DEF;
    localparam int REPORT_LIMIT = 10;
    // Covers the longest engine pass, a request for 16 of 16 nodes.
    localparam int SETTLE_CYCLES = 320;
    localparam int DRAIN_LIMIT   = 20000;
    localparam logic [lln_pkg::LOAD_BEFORE_W-1:0] LOAD_CEILING = '1;

    typedef struct packed {
        logic [lln_pkg::NODE_INDEX_W-1:0]  node;
        logic [lln_pkg::LOAD_BEFORE_W-1:0] load;
        logic                              last;
        logic                              err;
    } alloc_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [lln_pkg::CFG_W-1:0]          cfg_wr_data;
    logic                               req_valid;
    logic                               req_ready;
    logic [lln_pkg::REQ_COUNT_W-1:0]    request_count;
    logic                               res_valid;
    logic                               res_ready;
    logic [lln_pkg::NODE_INDEX_W-1:0]   node_index;
    logic [lln_pkg::LOAD_BEFORE_W-1:0]  load_before;
    logic                               last_of_run;
    logic                               request_error;

    logic [lln_pkg::LOAD_BEFORE_W-1:0]  load_model [NODE_COUNT];
    logic [lln_pkg::CFG_W-1:0]          pool_size;
    alloc_t                             expected_allocs [$];
    int                                 error_count;
    bit                                 tx_idle_on;
    bit                                 rx_idle_on;

    least_loaded_node_allocator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .request_count (request_count),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .node_index    (node_index),
        .load_before   (load_before),
        .last_of_run   (last_of_run),
        .request_error (request_error)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int active_nodes();
        return (pool_size > NODE_COUNT) ? NODE_COUNT : int'(pool_size);
    endfunction

    // Repeated minimum search over the untaken counters, ties to the lower index.
    function automatic void predict_allocation(logic [lln_pkg::REQ_COUNT_W-1:0] want);
        int                  used;
        int                  best;
        bit                  found;
        logic [NODE_COUNT-1:0] taken;
        alloc_t              item;
        used = active_nodes();
        if (want == 0)
            return;
        if (int'(want) > used)
        begin
            item = '{node: '0, load: '0, last: 1'b1, err: 1'b1};
            expected_allocs.insert(expected_allocs.size(), item);
            return;
        end
        taken = '0;
        for (int k = 0; k < int'(want); k++)
        begin
            best  = 0;
            found = 1'b0;
            for (int i = 0; i < used; i++)
            begin
                if (!taken[i] && (!found || load_model[i] < load_model[best]))
                begin
                    best  = i;
                    found = 1'b1;
                end
            end
            taken[best] = 1'b1;
            item.node = best[lln_pkg::NODE_INDEX_W-1:0];
            item.load = load_model[best];
            item.last = (k == int'(want) - 1);
            item.err  = 1'b0;
            expected_allocs.insert(expected_allocs.size(), item);
            if (load_model[best] != LOAD_CEILING)
                load_model[best] = load_model[best] + 1'b1;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [lln_pkg::REQ_COUNT_W-1:0] count);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid     = 1'b1;
        request_count = count;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        predict_allocation(count);
        @(negedge clk);
    endtask

    task automatic drain_allocations();
        int waited;
        req_valid = 1'b0;
        waited    = 0;
        while (expected_allocs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        // Give any stray result time to show up.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_pool_size(input logic [lln_pkg::CFG_W-1:0] value);
        drain_allocations();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        pool_size   = value;
    endtask

    task automatic test_directed_cases();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        // All loads equal after reset: ties resolve to the lowest indexes.
        send_request(5'd1);
        send_request(5'd1);
        send_request(5'd2);
        send_request(5'd16);
        send_request(5'd0);
        send_request(5'd17);
        send_request(5'd31);
        send_request(5'd5);
        send_request(5'd3);
        // Restrict the pool; counters above it must stay untouched.
        write_pool_size(5'd4);
        send_request(5'd4);
        send_request(5'd5);
        send_request(5'd2);
        write_pool_size(5'd1);
        send_request(5'd1);
        send_request(5'd2);
        send_request(5'd0);
        // An empty pool turns every nonzero request into an error.
        write_pool_size(5'd0);
        send_request(5'd1);
        send_request(5'd0);
        // Values above the node count act as the full pool.
        write_pool_size(5'd31);
        send_request(5'd16);
        send_request(5'd17);
        write_pool_size(5'd17);
        send_request(5'd16);
        write_pool_size(5'd16);
        send_request(5'd7);
    endtask

    task automatic test_random_traffic();
        int                              pick;
        int                              used;
        logic [lln_pkg::REQ_COUNT_W-1:0] count;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                write_pool_size(5'd16);
            else if (phase == 1)
                write_pool_size(5'd1);
            else if ($urandom_range(0, 99) < 20)
                write_pool_size(lln_pkg::CFG_W'($urandom_range(0, 31)));
            else
                write_pool_size(lln_pkg::CFG_W'($urandom_range(1, 16)));
            used = active_nodes();
            for (int n = 0; n < 20; n++)
            begin
                // Redraw idling every few transfers so quiet stretches appear.
                if (n % 8 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    count = '0;
                else if (pick < 18 || used == 0)
                    count = lln_pkg::REQ_COUNT_W'($urandom_range(0, 31));
                else
                    count = lln_pkg::REQ_COUNT_W'($urandom_range(1, used));
                send_request(count);
            end
        end
    endtask

    task automatic test_skewed_loads();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_pool_size(5'd1);
        // Pile requests onto node 0 so it runs well ahead of node 1.
        for (int n = 0; n < 8; n++)
            send_request(5'd1);
        write_pool_size(5'd2);
        send_request(5'd2);
        send_request(5'd1);
    endtask

    initial
    begin : result_monitor
        int     stall;
        alloc_t want;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                res_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready = 1'b1;
            do
                @(posedge clk);
            while (res_valid !== 1'b1);
            if (expected_allocs.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: node %0d load %0d last %b err %b",
                             node_index, load_before, last_of_run, request_error);
            end
            else
            begin
                want = expected_allocs.pop_front();
                if (node_index !== want.node || load_before !== want.load ||
                    last_of_run !== want.last || request_error !== want.err)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $write("mismatch: expected node %0d load %0d last %b err %b,",
                               want.node, want.load, want.last, want.err);
                        $display(" got node %0d load %0d last %b err %b",
                                 node_index, load_before, last_of_run, request_error);
                    end
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        #(8 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        req_valid     = 1'b0;
        request_count = '0;
        error_count   = 0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        pool_size     = lln_pkg::NODES_IN_USE_RESET;
        for (int i = 0; i < NODE_COUNT; i++)
            load_model[i] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_traffic();
        test_skewed_loads();

        drain_allocations();
        if (error_count == 0 && expected_allocs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/lln_pkg.sv
rtl/core/lln_front.sv
rtl/core/lln_queue.sv
rtl/core/lln_back.sv
rtl/core/least_loaded_node_allocator_core.sv
tb/sv/tb_least_loaded_node_allocator_core.sv
